@@ rtl/core/olid_pkg.sv @@
// Shared constants, codes and types of the ordered list unit.
package olid_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LIST   = 2'd2;

  localparam logic [2:0] STAT_INSERTED  = 3'd0;
  localparam logic [2:0] STAT_DELETED   = 3'd1;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd2;
  localparam logic [2:0] STAT_EMPTY     = 3'd3;
  localparam logic [2:0] STAT_FULL      = 3'd4;
  localparam logic [2:0] STAT_LISTED    = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REPORT,
    S_LIST
  } state_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                     restart;
    logic                     adv;
    logic                     scan;
    logic                     write;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

@@ rtl/core/olid_if.sv @@
// Request and result channel interfaces of the ordered list unit.
interface olid_in_if import olid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               op;
  logic signed [DATA_W-1:0] value;

  modport source(output valid, op, value, input ready);
  modport sink(input valid, op, value, output ready);
endinterface

interface olid_out_if import olid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [2:0]               status;
  logic signed [DATA_W-1:0] item;
  logic                     last;

  modport source(output valid, status, item, last, input ready);
  modport sink(input valid, status, item, last, output ready);
endinterface

@@ rtl/core/ordered_list_insert_delete_unit.sv @@
// Top level of the ordered list unit: controller plus a chain of storage cells.
//
//   channel | dir | word                          | accepted when
//   cmd     | in  | op[1:0], value[31:0]          | cmd.valid && cmd.ready
//   res     | out | status[2:0], item[31:0], last | res.valid && res.ready
//
// Insert, and any op on an empty list, answers straight from idle; opcode 3 is dropped.
// Delete walks the token once through the cell chain, count cells, then reports.
// Display returns count words, one word per cycle while res is not stalled.
// rst clears the fill count, the sequencer and the tokens; entries keep old data.
// One request at a time; cmd waits in ready low while res holds an untaken word.
module ordered_list_insert_delete_unit import olid_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  olid_in_if.sink    cmd,
  olid_out_if.source res
);

  cell_cmd_t                ctl;
  logic signed [DATA_W-1:0] data_a [CAPACITY];
  logic [CAPACITY-1:0]      tok_v;
  logic [CAPACITY-1:0]      hit_v;
  logic [CAPACITY-1:0]      hit_now_v;
  logic signed [DATA_W-1:0] sel_data;
  logic                     any_hit;

  olid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .res      (res),
    .any_hit  (any_hit),
    .sel_data (sel_data),
    .ctl      (ctl)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     tok_in;
    logic                     hit_in;
    logic signed [DATA_W-1:0] next_data;

    if (i == 0) begin : g_head
      assign tok_in = 1'b0;
      assign hit_in = 1'b0;
    end else begin : g_body
      assign tok_in = tok_v[i-1];
      assign hit_in = hit_v[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_data = '0;
    end else begin : g_link
      assign next_data = data_a[i+1];
    end

    olid_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .idx       (IDX_W'(i)),
      .ctl       (ctl),
      .tok_in    (tok_in),
      .hit_in    (hit_in),
      .next_data (next_data),
      .data      (data_a[i]),
      .tok       (tok_v[i]),
      .hit       (hit_v[i]),
      .hit_now   (hit_now_v[i])
    );
  end

  // token is one-hot, so an OR of gated entries picks the listed word
  always_comb begin
    sel_data = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      sel_data = sel_data | (tok_v[k] ? data_a[k] : '0);
    end
  end

  assign any_hit = |hit_now_v;

endmodule

@@ rtl/core/olid_cell.sv @@
// One storage cell of the list chain: holds an entry, passes the scan token on.
module olid_cell import olid_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [IDX_W-1:0]         idx,
  input  cell_cmd_t                ctl,
  input  logic                     tok_in,
  input  logic                     hit_in,
  input  logic signed [DATA_W-1:0] next_data,
  output logic signed [DATA_W-1:0] data,
  output logic                     tok,
  output logic                     hit,
  output logic                     hit_now
);

  logic match;
  logic take;

  assign match   = tok && (data == ctl.value);
  // once the match is at or before this cell, close up from the right neighbor
  assign take    = ctl.scan && ctl.adv && tok && (hit_in || match);
  assign hit_now = ctl.scan && match;

  always_ff @(posedge clk) begin
    if (ctl.write && (CNT_W'(idx) == ctl.count)) begin
      data <= ctl.value;
    end else if (take) begin
      data <= next_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= 1'b0;
      hit <= 1'b0;
    end else if (ctl.restart) begin
      tok <= (idx == '0);
      hit <= 1'b0;
    end else if (ctl.adv) begin
      tok <= tok_in;
      hit <= ctl.scan && tok && (hit_in || match);
    end
  end

endmodule

@@ rtl/core/olid_ctrl.sv @@
// Sequencer of the list unit: handshakes, fill count, result word register.
module olid_ctrl import olid_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  olid_in_if.sink                  cmd,
  olid_out_if.source               res,
  input  logic                     any_hit,
  input  logic signed [DATA_W-1:0] sel_data,
  output cell_cmd_t                ctl
);

  state_t                   state, state_next;
  logic [CNT_W-1:0]         count, count_next;
  logic [IDX_W-1:0]         step, step_next;
  logic                     found, found_next;
  logic signed [DATA_W-1:0] opnd, opnd_next;

  logic                     res_v;
  logic [2:0]               res_status;
  logic signed [DATA_W-1:0] res_item;
  logic                     res_last;

  logic                     load;
  logic [2:0]               load_status;
  logic signed [DATA_W-1:0] load_item;
  logic                     load_last;

  logic slot_free;
  logic accept;
  logic last_step;

  assign slot_free = !res_v || res.ready;
  assign cmd.ready = (state == S_IDLE) && slot_free;
  assign accept    = cmd.valid && cmd.ready;
  assign last_step = (CNT_W'(step) == (count - CNT_W'(1)));

  assign res.valid  = res_v;
  assign res.status = res_status;
  assign res.item   = res_item;
  assign res.last   = res_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      step  <= '0;
      found <= 1'b0;
      res_v <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      step  <= step_next;
      found <= found_next;
      if (load) begin
        res_v <= 1'b1;
      end else if (res.ready) begin
        res_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    opnd <= opnd_next;
    if (load) begin
      res_status <= load_status;
      res_item   <= load_item;
      res_last   <= load_last;
    end
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    step_next   = step;
    found_next  = found;
    opnd_next   = opnd;
    load        = 1'b0;
    load_status = STAT_EMPTY;
    load_item   = opnd;
    load_last   = 1'b1;
    ctl.restart = 1'b0;
    ctl.adv     = 1'b0;
    ctl.scan    = 1'b0;
    ctl.write   = 1'b0;
    ctl.count   = count;
    ctl.value   = (state == S_IDLE) ? cmd.value : opnd;

    case (state)
      S_IDLE: begin
        if (accept) begin
          opnd_next = cmd.value;
          case (cmd.op)
            OP_INSERT: begin
              load      = 1'b1;
              load_item = cmd.value;
              if (count == CNT_W'(CAPACITY)) begin
                load_status = STAT_FULL;
              end else begin
                load_status = STAT_INSERTED;
                ctl.write   = 1'b1;
                count_next  = count + CNT_W'(1);
              end
            end
            OP_DELETE: begin
              if (count == '0) begin
                load        = 1'b1;
                load_status = STAT_EMPTY;
                load_item   = cmd.value;
              end else begin
                ctl.restart = 1'b1;
                step_next   = '0;
                found_next  = 1'b0;
                state_next  = S_SCAN;
              end
            end
            OP_LIST: begin
              if (count == '0) begin
                load        = 1'b1;
                load_status = STAT_EMPTY;
                load_item   = '0;
              end else begin
                ctl.restart = 1'b1;
                step_next   = '0;
                state_next  = S_LIST;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        // token walks one cell a cycle; cells behind a match shift left
        ctl.scan   = 1'b1;
        ctl.adv    = 1'b1;
        found_next = found || any_hit;
        step_next  = step + IDX_W'(1);
        if (last_step) begin
          state_next = S_REPORT;
        end
      end

      S_REPORT: begin
        if (slot_free) begin
          load        = 1'b1;
          load_status = found ? STAT_DELETED : STAT_NOT_FOUND;
          load_item   = opnd;
          if (found) begin
            count_next = count - CNT_W'(1);
          end
          state_next = S_IDLE;
        end
      end

      S_LIST: begin
        if (slot_free) begin
          load        = 1'b1;
          load_status = STAT_LISTED;
          load_item   = sel_data;
          load_last   = last_step;
          ctl.adv     = 1'b1;
          step_next   = step + IDX_W'(1);
          if (last_step) begin
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/olid_checker.sv @@
// Port-level checks of the ordered list unit and their bind to the top level.
module olid_checker import olid_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     cmd_valid,
  input logic                     cmd_ready,
  input logic [1:0]               cmd_op,
  input logic signed [DATA_W-1:0] cmd_value,
  input logic                     res_valid,
  input logic                     res_ready,
  input logic [2:0]               res_status,
  input logic signed [DATA_W-1:0] res_item,
  input logic                     res_last
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result word dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=>
      $stable(res_status) && $stable(res_item) && $stable(res_last))
    else $error("stalled result word changed");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |-> !res_valid || res_ready)
    else $error("request taken while a result word is pending");

  a_insert_reply: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (cmd_op == OP_INSERT) |=>
      res_valid && res_last && (res_item == $past(cmd_value)) &&
      ((res_status == STAT_INSERTED) || (res_status == STAT_FULL)))
    else $error("insert did not answer in the next cycle");

endmodule

bind ordered_list_insert_delete_unit olid_checker u_olid_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .cmd_op     (cmd.op),
  .cmd_value  (cmd.value),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .res_status (res.status),
  .res_item   (res.item),
  .res_last   (res.last)
);

@@ bench/ordered_list_insert_delete_unit_tb.sv @@
// Self-checking testbench for the ordered list unit: directed table, then random traffic.
module ordered_list_insert_delete_unit_tb;
  import olid_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         CYCLE_LIMIT = 1_000_000;
  localparam int         PHASE_WORDS = 125;

  typedef struct {
    logic [2:0]               status;
    logic signed [DATA_W-1:0] item;
    logic                     last;
  } list_word_t;

  typedef struct {
    logic [1:0]               op;
    logic signed [DATA_W-1:0] value;
    bit                       typed;
    logic [2:0]               status;
    logic signed [DATA_W-1:0] item;
  } probe_row_t;

  // typed rows carry their single expected word; the others go to the predictor
  probe_row_t probe_rows [23] = '{
    '{OP_LIST,   32'sh0000_0000, 1'b1, STAT_EMPTY,     32'sh0000_0000},
    '{OP_DELETE, 32'sh8000_0000, 1'b1, STAT_EMPTY,     32'sh8000_0000},
    '{OP_UNUSED, 32'sh0000_0000, 1'b0, STAT_INSERTED,  32'sh0000_0000},
    '{OP_INSERT, 32'sh7fff_ffff, 1'b1, STAT_INSERTED,  32'sh7fff_ffff},
    '{OP_INSERT, 32'sh8000_0000, 1'b1, STAT_INSERTED,  32'sh8000_0000},
    '{OP_INSERT, 32'shffff_ffff, 1'b1, STAT_INSERTED,  32'shffff_ffff},
    '{OP_INSERT, 32'sh0000_0000, 1'b1, STAT_INSERTED,  32'sh0000_0000},
    '{OP_INSERT, 32'sh0000_0005, 1'b1, STAT_INSERTED,  32'sh0000_0005},
    '{OP_INSERT, 32'sh0000_0005, 1'b1, STAT_INSERTED,  32'sh0000_0005},
    '{OP_LIST,   32'sh0000_0000, 1'b0, STAT_INSERTED,  32'sh0000_0000},
    '{OP_DELETE, 32'sh0000_0005, 1'b1, STAT_DELETED,   32'sh0000_0005},
    '{OP_DELETE, 32'sh0000_3039, 1'b1, STAT_NOT_FOUND, 32'sh0000_3039},
    '{OP_DELETE, 32'sh7fff_ffff, 1'b1, STAT_DELETED,   32'sh7fff_ffff},
    '{OP_DELETE, 32'sh0000_0005, 1'b1, STAT_DELETED,   32'sh0000_0005},
    '{OP_LIST,   32'sh1234_5678, 1'b0, STAT_INSERTED,  32'sh0000_0000},
    '{OP_UNUSED, 32'shffff_ffff, 1'b0, STAT_INSERTED,  32'sh0000_0000},
    '{OP_DELETE, 32'shffff_ffff, 1'b1, STAT_DELETED,   32'shffff_ffff},
    '{OP_DELETE, 32'sh8000_0000, 1'b1, STAT_DELETED,   32'sh8000_0000},
    '{OP_DELETE, 32'sh0000_0000, 1'b1, STAT_DELETED,   32'sh0000_0000},
    '{OP_LIST,   32'shffff_ffff, 1'b1, STAT_EMPTY,     32'sh0000_0000},
    '{OP_INSERT, 32'shffff_fffe, 1'b1, STAT_INSERTED,  32'shffff_fffe},
    '{OP_LIST,   32'sh0000_0000, 1'b0, STAT_INSERTED,  32'sh0000_0000},
    '{OP_DELETE, 32'sh0000_0000, 1'b1, STAT_NOT_FOUND, 32'sh0000_0000}
  };

  logic clk;
  logic rst;

  olid_in_if  cmd_ch ();
  olid_out_if res_ch ();

  ordered_list_insert_delete_unit dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  // shadow copy of the store
  logic signed [DATA_W-1:0] shadow_vals [CAPACITY];
  int                       shadow_len;

  list_word_t expected_words [$];

  int send_idle_pct;
  int recv_stall_pct;
  bit                       typed_pending;
  logic [2:0]               typed_status;
  logic signed [DATA_W-1:0] typed_item;

  int fail_count;
  int items_sent;
  int words_checked;
  int status_seen [8];
  int cycle_count;
  int queue_depth;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               expected_words.size());
      $display("** ordered_list_insert_delete_unit: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic void push_word(input logic [2:0] status,
                                    input logic signed [DATA_W-1:0] item,
                                    input logic last);
    list_word_t w;
    w.status = status;
    w.item   = item;
    w.last   = last;
    expected_words.push_back(w);
  endfunction

  // applies one request to the shadow store and queues the words it yields
  function automatic void predict_list_op(input logic [1:0] op,
                                          input logic signed [DATA_W-1:0] val);
    int hit;
    hit = -1;
    case (op)
      OP_INSERT: begin
        if (shadow_len >= CAPACITY) begin
          push_word(STAT_FULL, val, 1'b1);
        end else begin
          shadow_vals[shadow_len] = val;
          shadow_len = shadow_len + 1;
          push_word(STAT_INSERTED, val, 1'b1);
        end
      end
      OP_DELETE: begin
        if (shadow_len == 0) begin
          push_word(STAT_EMPTY, val, 1'b1);
        end else begin
          for (int i = 0; i < shadow_len; i++)
            if (hit < 0 && shadow_vals[i] == val) hit = i;
          if (hit < 0) begin
            push_word(STAT_NOT_FOUND, val, 1'b1);
          end else begin
            for (int j = hit; j + 1 < shadow_len; j++) shadow_vals[j] = shadow_vals[j + 1];
            shadow_len = shadow_len - 1;
            push_word(STAT_DELETED, val, 1'b1);
          end
        end
      end
      OP_LIST: begin
        if (shadow_len == 0) begin
          push_word(STAT_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < shadow_len; i++)
            push_word(STAT_LISTED, shadow_vals[i], i == shadow_len - 1);
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        words_checked = words_checked + 1;
        status_seen[res_ch.status] = status_seen[res_ch.status] + 1;
        if (expected_words.size() == 0) begin
          $error("unexpected result word: status %0d item %0d last %0b",
                 res_ch.status, res_ch.item, res_ch.last);
          fail_count = fail_count + 1;
        end else begin
          if (res_ch.status !== expected_words[0].status) begin
            $error("status: expected %0d, got %0d", expected_words[0].status, res_ch.status);
            fail_count = fail_count + 1;
          end
          if (res_ch.item !== expected_words[0].item) begin
            $error("item: expected %0d, got %0d", expected_words[0].item, res_ch.item);
            fail_count = fail_count + 1;
          end
          if (res_ch.last !== expected_words[0].last) begin
            $error("last: expected %0b, got %0b", expected_words[0].last, res_ch.last);
            fail_count = fail_count + 1;
          end
          void'(expected_words.pop_front());
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        queue_depth = expected_words.size();
        predict_list_op(cmd_ch.op, cmd_ch.value);
        if (typed_pending) begin
          while (expected_words.size() > queue_depth) void'(expected_words.pop_back());
          push_word(typed_status, typed_item, 1'b1);
        end
      end
    end
  end

  // entered and left at a falling edge with nothing yet driven in that step
  task automatic send_word(input logic [1:0] op, input logic signed [DATA_W-1:0] val,
                           input bit typed, input logic [2:0] t_status,
                           input logic signed [DATA_W-1:0] t_item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    typed_pending = typed;
    typed_status  = t_status;
    typed_item    = t_item;
    cmd_ch.valid <= 1'b1;
    cmd_ch.op    <= op;
    cmd_ch.value <= val;
    do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
    if (op != OP_UNUSED) items_sent = items_sent + 1;
    @(negedge clk);
  endtask

  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    do @(negedge clk); while (expected_words.size() != 0);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return $urandom_range(0, 1) ? 32'sh0000_0000 : 32'shffff_ffff;
      3, 4, 5: return $signed($urandom_range(0, 15)) - 8;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int  pick;
    int  target;
    bit  growing;
    logic [1:0]               op;
    logic signed [DATA_W-1:0] val;

    rst            = 1'b1;
    cmd_ch.valid   = 1'b0;
    cmd_ch.op      = OP_INSERT;
    cmd_ch.value   = '0;
    res_ch.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    typed_pending  = 1'b0;
    typed_status   = STAT_INSERTED;
    typed_item     = '0;
    fail_count     = 0;
    items_sent     = 0;
    words_checked  = 0;
    cycle_count    = 0;
    shadow_len     = 0;
    growing        = 1'b1;
    foreach (status_seen[i]) status_seen[i] = 0;
    foreach (shadow_vals[i]) shadow_vals[i] = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (probe_rows[r])
      send_word(probe_rows[r].op, probe_rows[r].value, probe_rows[r].typed,
                probe_rows[r].status, probe_rows[r].item);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      target = items_sent + PHASE_WORDS;
      while (items_sent < target) begin
        // swing between filling up to full and emptying out
        if (shadow_len >= CAPACITY && $urandom_range(0, 99) < 30) growing = 1'b0;
        else if (shadow_len == 0) growing = 1'b1;
        else if ($urandom_range(0, 99) < 2) growing = !growing;
        pick = $urandom_range(0, 99);
        if (pick < 5)                        op = OP_UNUSED;
        else if (pick < 20)                  op = OP_LIST;
        else if (growing ? pick < 85 : pick < 40) op = OP_INSERT;
        else                                 op = OP_DELETE;
        val = pick_value();
        if (op == OP_DELETE && shadow_len > 0 && $urandom_range(0, 99) < 75)
          val = shadow_vals[$urandom_range(0, shadow_len - 1)];
        send_word(op, val, 1'b0, STAT_INSERTED, '0);
      end
      // let the unit go fully quiet before changing traffic shape
      drain_results();
    end

    recv_stall_pct = 0;
    repeat (2 * CAPACITY + 8) @(negedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d expected result words never arrived", expected_words.size());
      fail_count = fail_count + 1;
    end

    $display("Ran %0d requests, checked %0d result words in %0d cycles.",
             items_sent, words_checked, cycle_count);
    $display("Seen: %0d inserted, %0d deleted, %0d misses, %0d empty, %0d full, %0d listed.",
             status_seen[STAT_INSERTED], status_seen[STAT_DELETED],
             status_seen[STAT_NOT_FOUND], status_seen[STAT_EMPTY],
             status_seen[STAT_FULL], status_seen[STAT_LISTED]);
    if (fail_count == 0) begin
      $display("** ordered_list_insert_delete_unit: PASSED **");
    end else begin
      $display("** ordered_list_insert_delete_unit: FAILED **");
    end
    $finish;
  end

endmodule
